/* src/ors_pkg.sv */
`timescale 1ns / 1ps

package ors_pkg;

  localparam int RomBits   = 64;
  localparam int ReqBytes  = 16;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);
  localparam logic [6:0] DiscLimit = 7'd63;
  localparam logic [7:0] CrcPoly   = 8'h8C;

  typedef enum logic [1:0] {
    MODE_NEW,
    MODE_NEXT,
    MODE_RESP
  } mode_e;

  typedef enum logic [1:0] {
    OP_NEW,
    OP_NEXT,
    OP_RESP,
    OP_FINAL
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REQ,
    BK_CHECK
  } bk_state_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] idx;
    logic [7:0] data;
  } job_t;

  // Reflected CRC8, x^8+x^5+x^4+1, one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/onewire_rom_search_accelerator.sv */
`timescale 1ns / 1ps
// A begin command and a final response byte each pass the queue and the idle state;
//   the request state then registers the first request byte, the check state the result.
// Throughput: a begin command yields 16 request bytes, one per cycle while pop keeps up;
//   each response byte is folded in the idle state; the sixteenth is then checked for CRC.
// Response bytes are folded into ROM, discrepancy and CRC as they arrive.
// Reset (rst, synchronous) clears the search state, byte count, queue and result valid flag.

module onewire_rom_search_accelerator
  import ors_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         mode,
  input  logic [7:0]         response_byte,
  output logic               empty,
  input  logic               pop,
  output logic               kind,
  output logic [7:0]         request_byte,
  output logic [RomBits-1:0] rom_code,
  output logic               last_device,
  output logic               status,
  output logic [3:0]         family_discrepancy,
  output logic               last
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  job_t wr_job;
  job_t rd_job;

  ors_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .mode          (mode),
    .response_byte (response_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (wr_job)
  );

  ors_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_job  (wr_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_valid (q_valid),
    .rd_job  (rd_job)
  );

  ors_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_job              (rd_job),
    .q_pop              (q_pop),
    .empty              (empty),
    .pop                (pop),
    .kind               (kind),
    .request_byte       (request_byte),
    .rom_code           (rom_code),
    .last_device        (last_device),
    .status             (status),
    .family_discrepancy (family_discrepancy),
    .last               (last)
  );

endmodule

/* src/ors_queue.sv */
`timescale 1ns / 1ps

module ors_queue
  import ors_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic q_full,
  input  logic rd_en,
  output logic q_valid,
  output job_t rd_job
);

  job_t             slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == QCntW'(QDepth));
  assign q_valid = (count != '0);
  assign rd_job  = slots[rd_ptr];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/ors_front.sv */
`timescale 1ns / 1ps

module ors_front
  import ors_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] mode,
  input  logic [7:0] response_byte,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [3:0] byte_cnt;
  logic [3:0] byte_cnt_next;
  logic       xfer;

  assign full = q_full;
  assign xfer = push && !q_full;

  always_comb begin
    byte_cnt_next = byte_cnt;
    q_push        = 1'b0;
    q_job.op      = OP_NEW;
    q_job.idx     = byte_cnt;
    q_job.data    = response_byte;
    if (xfer) begin
      case (mode_e'(mode))
        MODE_NEW: begin
          byte_cnt_next = '0;
          q_push        = 1'b1;
          q_job.op      = OP_NEW;
        end
        MODE_NEXT: begin
          byte_cnt_next = '0;
          q_push        = 1'b1;
          q_job.op      = OP_NEXT;
        end
        MODE_RESP: begin
          byte_cnt_next = byte_cnt + 1'b1;
          q_push        = 1'b1;
          q_job.op      = (byte_cnt == 4'(ReqBytes - 1)) ? OP_FINAL : OP_RESP;
        end
        default: begin
          // unused mode: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= '0;
    end else begin
      byte_cnt <= byte_cnt_next;
    end
  end

endmodule

/* src/ors_back.sv */
`timescale 1ns / 1ps

module ors_back
  import ors_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  job_t               q_job,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic               kind,
  output logic [7:0]         request_byte,
  output logic [RomBits-1:0] rom_code,
  output logic               last_device,
  output logic               status,
  output logic [3:0]         family_discrepancy,
  output logic               last
);

  bk_state_e          state, state_next;

  // search state
  logic [RomBits-1:0] rom_store, rom_store_next;
  logic [6:0]         disc, disc_next;
  logic [3:0]         fam_pos, fam_pos_next;
  logic               done, done_next;

  // response accumulation
  logic [RomBits-1:0] acc_rom, acc_rom_next;
  logic [6:0]         acc_lz, acc_lz_next;
  logic [3:0]         acc_fam, acc_fam_next;
  logic [7:0]         acc_crc, acc_crc_next;

  logic [3:0]         req_cnt, req_cnt_next;

  // result register
  logic               out_valid, out_valid_next;
  logic               load;
  logic               ld_kind, ld_last_device, ld_status, ld_last;
  logic [7:0]         ld_req;
  logic [RomBits-1:0] ld_rom;
  logic [3:0]         ld_fam;

  logic               out_free;
  logic               search_err;
  logic               lz_zero;
  logic [7:0]         req_calc;
  logic [5:0]         bit_pos;
  logic [6:0]         bit_num;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // request byte for the current count: direction bits on odd positions
  always_comb begin
    req_calc = '0;
    bit_pos  = '0;
    bit_num  = '0;
    for (int j = 0; j < 4; j++) begin
      bit_pos = {req_cnt, 2'(j)};
      bit_num = {1'b0, bit_pos} + 7'd1;
      if (bit_num < disc) begin
        req_calc[2*j+1] = rom_store[bit_pos];
      end else begin
        req_calc[2*j+1] = (bit_num == disc);
      end
    end
  end

  assign search_err = (acc_crc != 8'd0) || (disc == DiscLimit) || (acc_rom[7:0] == 8'd0);
  assign lz_zero    = (acc_lz == 7'd0);

  // fold one response byte: four direction bits and four conflict bits
  always_comb begin
    acc_rom_next = acc_rom;
    acc_lz_next  = (q_job.idx == 4'd0) ? 7'd0 : acc_lz;
    acc_fam_next = (q_job.idx == 4'd0) ? fam_pos : acc_fam;
    acc_crc_next = (q_job.idx == 4'd1) ? 8'd0 : acc_crc;
    for (int j = 0; j < 4; j++) begin
      acc_rom_next[{q_job.idx, 2'(j)}] = q_job.data[2*j+1];
      if (q_job.data[2*j] && !q_job.data[2*j+1]) begin
        acc_lz_next = {1'b0, q_job.idx, 2'(j)} + 7'd1;
        if (q_job.idx < 4'd2) begin
          acc_fam_next = {1'b0, q_job.idx[0], 2'(j)} + 4'd1;
        end
      end
    end
    // a ROM byte completes on every odd response byte
    if (q_job.idx[0]) begin
      acc_crc_next = crc8_byte(acc_crc_next, acc_rom_next[{q_job.idx[3:1], 3'b000} +: 8]);
    end
  end

  always_comb begin
    state_next     = state;
    rom_store_next = rom_store;
    disc_next      = disc;
    fam_pos_next   = fam_pos;
    done_next      = done;
    req_cnt_next   = req_cnt;
    q_pop          = 1'b0;
    load           = 1'b0;
    ld_kind        = 1'b0;
    ld_req         = '0;
    ld_rom         = '0;
    ld_last_device = 1'b0;
    ld_status      = 1'b0;
    ld_fam         = '0;
    ld_last        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_job.op)
            OP_NEW: begin
              rom_store_next = '0;
              disc_next      = '0;
              fam_pos_next   = '0;
              done_next      = 1'b0;
              req_cnt_next   = '0;
              state_next     = BK_REQ;
            end
            OP_NEXT: begin
              req_cnt_next = '0;
              state_next   = BK_REQ;
            end
            OP_FINAL: begin
              state_next = BK_CHECK;
            end
            default: begin
            end
          endcase
        end
      end
      BK_REQ: begin
        if (out_free) begin
          load         = 1'b1;
          ld_req       = req_calc;
          ld_last      = (req_cnt == 4'(ReqBytes - 1));
          req_cnt_next = req_cnt + 1'b1;
          if (req_cnt == 4'(ReqBytes - 1)) begin
            state_next = BK_IDLE;
          end
        end
      end
      BK_CHECK: begin
        if (out_free) begin
          load       = 1'b1;
          ld_kind    = 1'b1;
          ld_last    = 1'b1;
          state_next = BK_IDLE;
          if (search_err) begin
            disc_next    = '0;
            fam_pos_next = '0;
            done_next    = 1'b0;
            ld_status    = 1'b1;
          end else begin
            rom_store_next = acc_rom;
            disc_next      = acc_lz;
            fam_pos_next   = acc_fam;
            done_next      = done || lz_zero;
            ld_rom         = acc_rom;
            ld_last_device = done || lz_zero;
            ld_fam         = acc_fam;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    out_valid_next = (out_valid && !pop) || load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rom_store <= '0;
      disc      <= '0;
      fam_pos   <= '0;
      done      <= 1'b0;
      req_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rom_store <= rom_store_next;
      disc      <= disc_next;
      fam_pos   <= fam_pos_next;
      done      <= done_next;
      req_cnt   <= req_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_valid && (q_job.op == OP_RESP || q_job.op == OP_FINAL)) begin
      acc_rom <= acc_rom_next;
      acc_lz  <= acc_lz_next;
      acc_fam <= acc_fam_next;
      acc_crc <= acc_crc_next;
    end
    if (load) begin
      kind               <= ld_kind;
      request_byte       <= ld_req;
      rom_code           <= ld_rom;
      last_device        <= ld_last_device;
      status             <= ld_status;
      family_discrepancy <= ld_fam;
      last               <= ld_last;
    end
  end

endmodule

/* src/ors_checker.sv */
`timescale 1ns / 1ps

module ors_checker
  import ors_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic               kind,
  input logic [7:0]         request_byte,
  input logic [RomBits-1:0] rom_code,
  input logic               last_device,
  input logic               status,
  input logic [3:0]         family_discrepancy,
  input logic               last
);

  a_req_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && !kind) |-> (rom_code == '0 && !status && !last_device
                           && family_discrepancy == 4'd0))
    else $error("request item carries result fields");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind && status) |-> (rom_code == '0 && !last_device
                                    && family_discrepancy == 4'd0))
    else $error("error result carries ROM data");

  a_result_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind) |-> (last && request_byte == 8'd0))
    else $error("search result not marked last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(request_byte)
                          && $stable(rom_code) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind onewire_rom_search_accelerator ors_checker u_ors_checker (
  .clk                (clk),
  .rst                (rst),
  .empty              (empty),
  .pop                (pop),
  .kind               (kind),
  .request_byte       (request_byte),
  .rom_code           (rom_code),
  .last_device        (last_device),
  .status             (status),
  .family_discrepancy (family_discrepancy),
  .last               (last)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ors_pkg::*;

  localparam logic [1:0] ModeUnused   = 2'd3;
  localparam logic       KindRequest  = 1'b0;
  localparam logic       KindResult   = 1'b1;
  localparam logic       StatusOk     = 1'b0;
  localparam logic       StatusError  = 1'b1;
  localparam int         TargetItems  = 460;
  localparam int         LongHold     = 400;
  localparam int         WatchdogLimit = 5000;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  req;
    logic [63:0] rom;
    logic        lastdev;
    logic        st;
    logic [3:0]  fam;
    logic        lst;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode = MODE_NEW;
  logic [7:0]  response_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind;
  logic [7:0]  request_byte;
  logic [63:0] rom_code;
  logic        last_device;
  logic        status;
  logic [3:0]  family_discrepancy;
  logic        last;

  onewire_rom_search_accelerator u_top (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .mode               (mode),
    .response_byte      (response_byte),
    .empty              (empty),
    .pop                (pop),
    .kind               (kind),
    .request_byte       (request_byte),
    .rom_code           (rom_code),
    .last_device        (last_device),
    .status             (status),
    .family_discrepancy (family_discrepancy),
    .last               (last)
  );

  always #4 clk = ~clk;

  // search state as the block should hold it
  logic [7:0]  resp_bytes [16];
  logic [3:0]  resp_cnt = '0;
  logic [63:0] srch_rom = '0;
  logic [6:0]  srch_disc = '0;
  logic [3:0]  srch_fam = '0;
  logic        srch_done = 1'b0;

  cmd_t        pending [$];
  result_t     due_results [$];
  logic [63:0] bus [$];

  int  items_queued = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  bit  in_xfer = 1'b0;
  bit  out_xfer = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  burst_left = 1;
  int  gap_left = 0;
  int  phase_left = 0;
  int  stall_style = 0;
  int  pat_cnt = 0;
  result_t got, want;

  // Dallas CRC8, bit-serial, LSB first
  function automatic logic [7:0] crc_bits(input logic [63:0] v, input int n);
    logic [7:0] c;
    logic       fb;
    c = '0;
    for (int i = 0; i < n; i++) begin
      fb = c[0] ^ v[i];
      c = c >> 1;
      if (fb) c = c ^ 8'h8C;
    end
    return c;
  endfunction

  // direction bits on odd positions: ROM below the discrepancy, 1 at it, 0 above
  function automatic logic [127:0] search_pattern();
    logic [127:0] pat;
    pat = '0;
    for (int i = 0; i < RomBits; i++) begin
      if (i + 1 < srch_disc) pat[2*i+1] = srch_rom[i];
      else if (i + 1 == srch_disc) pat[2*i+1] = 1'b1;
    end
    return pat;
  endfunction

  task automatic queue_requests();
    logic [127:0] pat;
    pat = search_pattern();
    for (int k = 0; k < ReqBytes; k++)
      due_results.push_back('{KindRequest, pat[8*k +: 8], 64'h0, 1'b0, StatusOk, 4'h0,
                              k == ReqBytes - 1});
  endtask

  task automatic finish_search();
    logic [127:0] r;
    logic [63:0]  rom;
    logic [6:0]   hi;
    logic [3:0]   fam;
    for (int k = 0; k < 16; k++) r[8*k +: 8] = resp_bytes[k];
    rom = '0;
    hi = '0;
    fam = srch_fam;
    for (int i = 0; i < RomBits; i++) begin
      rom[i] = r[2*i+1];
      if (r[2*i] && !r[2*i+1]) begin
        hi = 7'(i + 1);
        if (i < 8) fam = 4'(i + 1);
      end
    end
    if (crc_bits(rom, 64) != 8'h00 || srch_disc == DiscLimit || rom[7:0] == 8'h00) begin
      srch_disc = '0;
      srch_fam = '0;
      srch_done = 1'b0;
      due_results.push_back('{KindResult, 8'h00, 64'h0, 1'b0, StatusError, 4'h0, 1'b1});
    end else begin
      srch_fam = fam;
      srch_disc = hi;
      if (hi == 0) srch_done = 1'b1;
      srch_rom = rom;
      due_results.push_back('{KindResult, 8'h00, rom, srch_done, StatusOk, fam, 1'b1});
    end
  endtask

  task automatic advance_search(input logic [1:0] m, input logic [7:0] d);
    case (m)
      MODE_NEW: begin
        srch_rom = '0;
        srch_disc = '0;
        srch_fam = '0;
        srch_done = 1'b0;
        resp_cnt = '0;
        queue_requests();
      end
      MODE_NEXT: begin
        resp_cnt = '0;
        queue_requests();
      end
      MODE_RESP: begin
        resp_bytes[resp_cnt] = d;
        if (resp_cnt == 4'd15) begin
          resp_cnt = '0;
          finish_search();
        end else begin
          resp_cnt = resp_cnt + 4'd1;
        end
      end
      default: ;
    endcase
  endtask

  // stimulus helpers
  function automatic logic [63:0] make_rom(input logic [7:0] fam);
    logic [63:0] body;
    logic [55:0] low;
    body = {$urandom, $urandom};
    low = {body[47:0], fam};
    return {crc_bits({8'h00, low}, 56), low};
  endfunction

  function automatic logic [63:0] near_rom(input logic [63:0] rom);
    logic [55:0] low;
    low = rom[55:0];
    low[$urandom_range(0, 55)] ^= 1'b1;
    return {crc_bits({8'h00, low}, 56), low};
  endfunction

  function automatic logic [127:0] pack_response(input logic [63:0] rom,
                                                  input logic [63:0] conf);
    logic [127:0] r;
    for (int i = 0; i < RomBits; i++) begin
      r[2*i+1] = rom[i];
      r[2*i] = conf[i];
    end
    return r;
  endfunction

  // answer of the devices on the bus to one search pass
  function automatic logic [127:0] bus_answer(input logic [127:0] pat);
    logic [127:0] r;
    logic [15:0]  alive;
    logic         ones, zeros, pick;
    r = '0;
    alive = '1;
    for (int i = 0; i < RomBits; i++) begin
      ones = 1'b0;
      zeros = 1'b0;
      for (int j = 0; j < bus.size(); j++) begin
        if (alive[j]) begin
          if (bus[j][i]) ones = 1'b1;
          else zeros = 1'b1;
        end
      end
      pick = (ones && zeros) ? pat[2*i+1] : ones;
      r[2*i+1] = pick;
      r[2*i] = ones && zeros;
      for (int j = 0; j < bus.size(); j++)
        if (bus[j][i] != pick) alive[j] = 1'b0;
    end
    return r;
  endfunction

  task automatic new_bus();
    int n;
    n = $urandom_range(1, 5);
    bus.delete();
    bus.push_back(make_rom(8'($urandom_range(1, 255))));
    while (bus.size() < n) begin
      if ($urandom_range(0, 1) == 0) bus.push_back(near_rom(bus[$urandom_range(0, bus.size() - 1)]));
      else bus.push_back(make_rom(8'($urandom_range(1, 255))));
    end
  endtask

  task automatic queue_cmd(input logic [1:0] m, input logic [7:0] d);
    pending.push_back('{m, d});
    if (m != ModeUnused) items_queued++;
  endtask

  task automatic send_pass(input logic [1:0] m, input logic [127:0] resp);
    queue_cmd(m, 8'($urandom_range(0, 255)));
    for (int k = 0; k < 16; k++) queue_cmd(MODE_RESP, resp[8*k +: 8]);
  endtask

  function automatic logic [1:0] any_begin();
    return ($urandom_range(0, 1) == 0) ? MODE_NEW : MODE_NEXT;
  endfunction

  task automatic wait_sent();
    while (pending.size() != 0) @(negedge clk);
  endtask

  // monitor: transfers, checking, watchdog
  always @(posedge clk) begin
    in_xfer = !rst && push && !full;
    out_xfer = !rst && pop && !empty;
    if (in_xfer) advance_search(mode, response_byte);
    if (out_xfer) begin
      got = '{kind, request_byte, rom_code, last_device, status, family_discrepancy, last};
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind=%0d req=%02h rom=%016h", kind, request_byte,
                   rom_code);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp: kind=%0d req=%02h rom=%016h dev=%0d st=%0d fam=%0d last=%0d",
                     want.kind, want.req, want.rom, want.lastdev, want.st, want.fam, want.lst);
            $display("         got: kind=%0d req=%02h rom=%016h dev=%0d st=%0d fam=%0d last=%0d",
                     got.kind, got.req, got.rom, got.lastdev, got.st, got.fam, got.lst);
          end
        end
      end
    end
    if (in_xfer || out_xfer) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // driver: bursts of transfers with random gaps
  always @(negedge clk) begin
    if (in_xfer) begin
      void'(pending.pop_front());
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
    if (rst || pending.size() == 0 || gap_left > 0) begin
      if (gap_left > 0) gap_left--;
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      mode <= pending[0].mode;
      response_byte <= pending[0].data;
    end
  end

  // receiver: stall pattern changes from phase to phase of random length
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LongHold;
      hold_req = 1'b0;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (phase_left <= 0) begin
        stall_style = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      pat_cnt++;
      case (stall_style)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= (pat_cnt % 4 == 0);
        default: pop <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin
    logic [127:0] resp;
    logic [63:0]  rom;
    bit           hold_done;
    bit           pause_done;
    int           pick;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // ignored mode, stray bytes before any begin, restart, all-ones response
    queue_cmd(ModeUnused, 8'hFF);
    queue_cmd(MODE_RESP, 8'h00);
    queue_cmd(MODE_RESP, 8'h55);
    queue_cmd(MODE_RESP, 8'hAA);
    queue_cmd(MODE_NEXT, 8'h00);
    for (int k = 0; k < 16; k++) queue_cmd(MODE_RESP, 8'hFF);

    new_bus();
    while (items_queued < TargetItems) begin
      wait_sent();
      if (!hold_done && items_queued >= 150) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
      end
      if (!pause_done && items_queued >= 300) begin
        pause_done = 1'b1;
        while (due_results.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 5) == 0) begin
          new_bus();
          send_pass(MODE_NEW, bus_answer('0));
        end else begin
          send_pass(MODE_NEXT, bus_answer(search_pattern()));
        end
      end else if (pick < 70) begin
        resp = bus_answer(search_pattern());
        resp[$urandom_range(0, 127)] ^= 1'b1;
        send_pass(MODE_NEXT, resp);
      end else if (pick < 76) begin
        send_pass(MODE_NEW, pack_response(make_rom(8'h00), '0));
      end else if (pick < 84) begin
        // conflict at CRC bit 62 leaves a discrepancy of 63 behind
        rom = make_rom(8'($urandom_range(1, 255)));
        while (rom[62]) rom = make_rom(8'($urandom_range(1, 255)));
        send_pass(MODE_NEW, pack_response(rom, 64'h1 << 62));
      end else if (pick < 90) begin
        queue_cmd(any_begin(), 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 15)) queue_cmd(MODE_RESP, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 3)) queue_cmd(ModeUnused, 8'($urandom_range(0, 255)));
        send_pass(any_begin(), {$urandom, $urandom, $urandom, $urandom});
      end else begin
        send_pass(any_begin(), ($urandom_range(0, 1) == 0) ? '0 : '1);
      end
    end

    wait_sent();
    while (due_results.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ors_pkg.sv
src/ors_queue.sv
src/ors_front.sv
src/ors_back.sv
src/onewire_rom_search_accelerator.sv
src/ors_checker.sv
sim/tb.sv
